### src/gf2_512_multiplier_assert.svh
// assertion macros for the gf2 512 multiplier
// used by gfm_engine
`ifndef GF2_512_MULTIPLIER_ASSERT_SVH
`define GF2_512_MULTIPLIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("gfm check failed");
`define GFM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("gfm check failed");
`else
`define GFM_ASSERT(lbl, clk, rst_n, prop)
`define GFM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### src/gfm_pkg.sv
// shared constants and types of the gf2 512 multiplier
// no dependencies
`default_nettype none
package gfm_pkg;
  localparam int unsigned FieldBits = 512;
  localparam int unsigned WordBits = 64;
  localparam int unsigned DigitBits = 8;
  localparam logic [WordBits-1:0] ReductionLow = 64'h125;

  // job handed from the front to the engine
  typedef struct packed {
    logic [FieldBits-1:0] lhs;
    logic [FieldBits-1:0] rhs;
  } gfm_job_t;

  // multiply a by x^DigitBits modulo the field polynomial
  function automatic logic [FieldBits-1:0] gfm_shift_digit(input logic [FieldBits-1:0] a);
    logic [FieldBits-1:0] r;
    logic [DigitBits-1:0] top;
    logic [WordBits-1:0] fold;
    r = a << DigitBits;
    top = a[FieldBits-1 -: DigitBits];
    fold = '0;
    for (int i = 0; i < DigitBits; i++) begin
      if (top[i]) fold = fold ^ (ReductionLow << i);
    end
    r[WordBits-1:0] = r[WordBits-1:0] ^ fold;
    return r;
  endfunction
endpackage
`default_nettype wire

### src/gfm_front.sv
// front: collects operand words and hands a full job to the engine
// depends on gfm_pkg
`default_nettype none
module gfm_front #(
  parameter int unsigned FIELD_BITS = gfm_pkg::FieldBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [2:0]                  word_index_i,
  input  wire logic [gfm_pkg::WordBits-1:0] lhs_word_i,
  input  wire logic [gfm_pkg::WordBits-1:0] rhs_word_i,
  input  wire logic                        start_product_i,
  output logic                             job_valid_o,
  input  wire logic                        job_ready_i,
  output gfm_pkg::gfm_job_t                job_o
);
  import gfm_pkg::*;
  logic [FIELD_BITS-1:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic                  pend_q, pend_d;
  logic                  xfer;

  // a pending job blocks loading until the engine takes it
  assign full_o      = pend_q;
  assign xfer        = push_i && !pend_q;
  assign job_valid_o = pend_q;
  assign job_o.lhs   = lhs_q;
  assign job_o.rhs   = rhs_q;

  always_comb begin
    lhs_d  = lhs_q;
    rhs_d  = rhs_q;
    pend_d = pend_q;
    if (pend_q && job_ready_i) begin
      lhs_d  = '0;
      rhs_d  = '0;
      pend_d = 1'b0;
    end
    if (xfer) begin
      lhs_d[word_index_i*WordBits +: WordBits] = lhs_word_i;
      rhs_d[word_index_i*WordBits +: WordBits] = rhs_word_i;
      pend_d = start_product_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhs_q  <= '0;
      rhs_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      lhs_q  <= lhs_d;
      rhs_q  <= rhs_d;
      pend_q <= pend_d;
    end
  end
endmodule
`default_nettype wire

### src/gfm_engine.sv
// back: digit-serial multiply with reduction, then streams eight words
// depends on gfm_pkg and the assertion header
`default_nettype none
`include "gf2_512_multiplier_assert.svh"
module gfm_engine #(
  parameter int unsigned FIELD_BITS = gfm_pkg::FieldBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  output logic                              job_ready_o,
  input  gfm_pkg::gfm_job_t                 job_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [2:0]                        result_index_o,
  output logic [gfm_pkg::WordBits-1:0]      result_word_o,
  output logic                              result_last_o
);
  import gfm_pkg::*;
  localparam int unsigned Digits = FIELD_BITS / DigitBits;
  localparam int unsigned CntW = $clog2(Digits);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]            st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [2:0]            idx_q, idx_d;
  logic [FIELD_BITS-1:0] acc_q, acc_d, b_q, b_d;
  logic [FIELD_BITS-1:0] term;
  logic [DigitBits-1:0]  dig;
  logic                  mul_last;
  logic                  out_wait;

  assign job_ready_o    = (st_q == StIdle);
  assign empty_o        = (st_q != StOut);
  assign result_index_o = idx_q;
  assign result_word_o  = acc_q[idx_q*WordBits +: WordBits];
  assign result_last_o  = (idx_q == 3'd7);
  assign mul_last       = (st_q == StMul) && (cnt_q == CntW'(Digits - 1));
  assign out_wait       = (st_q == StOut) && !pop_i;

  // pow_q holds precomputed lhs * x^i for i below DigitBits, one per digit bit
  logic [FIELD_BITS-1:0] lhs_pow [DigitBits];
  always_comb begin
    lhs_pow[0] = job_i.lhs;
    for (int i = 1; i < DigitBits; i++) begin
      lhs_pow[i] = lhs_pow[i-1] << 1;
      if (lhs_pow[i-1][FIELD_BITS-1]) lhs_pow[i][WordBits-1:0] =
        lhs_pow[i][WordBits-1:0] ^ ReductionLow;
    end
  end
  logic [FIELD_BITS-1:0] pow_q [DigitBits];

  // horner over digits of b, most significant first
  always_comb begin
    term = gfm_shift_digit(acc_q);
    dig  = b_q[FIELD_BITS-1 -: DigitBits];
    for (int i = 0; i < DigitBits; i++) begin
      if (dig[i]) term = term ^ pow_q[i];
    end
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    acc_d = acc_q;
    b_d   = b_q;
    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          st_d  = StMul;
          cnt_d = '0;
          acc_d = '0;
          b_d   = job_i.rhs;
        end
      end
      StMul: begin
        acc_d = term;
        b_d   = b_q << DigitBits;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Digits - 1)) begin
          st_d  = StOut;
          idx_d = '0;
        end
      end
      StOut: begin
        if (pop_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && job_valid_i) begin
      for (int i = 0; i < DigitBits; i++) pow_q[i] <= lhs_pow[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  `GFM_ASSERT(a_mul_ends, clk_i, rst_ni, mul_last |=> (st_q == StOut && idx_q == 3'd0))
  `GFM_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> (st_q == StOut && $stable(idx_q)))
  `GFM_ASSERT_NEVER(a_bad_state, clk_i, rst_ni, (st_q != StIdle && st_q != StMul && st_q != StOut))
  `GFM_ASSERT(a_take_job, clk_i, rst_ni, (job_valid_i && job_ready_o) |=> (st_q == StMul && cnt_q == '0))
endmodule
`default_nettype wire

### src/gf2_512_multiplier.sv
// top level of the gf2 512 multiplier
// depends on gfm_pkg, gfm_front, gfm_engine
//
// channel  | handshake     | fields
// input    | push/full     | word_index_i lhs_word_i rhs_word_i start_product_i
// result   | empty/pop     | result_index_o result_word_o result_last_o
//
// a product runs through the digit-serial multiply loop (8 bits per cycle)
// once the engine takes the job, and then streams eight words.
// full rises after a start item and falls when the engine takes the job.
// reset clears the operand stores and control; result words wait for pop.
`default_nettype none
module gf2_512_multiplier #(
  parameter int unsigned FIELD_BITS = gfm_pkg::FieldBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [2:0]                   word_index_i,
  input  wire logic [gfm_pkg::WordBits-1:0] lhs_word_i,
  input  wire logic [gfm_pkg::WordBits-1:0] rhs_word_i,
  input  wire logic                         start_product_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [2:0]                        result_index_o,
  output logic [gfm_pkg::WordBits-1:0]      result_word_o,
  output logic                              result_last_o
);
  import gfm_pkg::*;
  logic     job_valid, job_ready;
  gfm_job_t job;

  gfm_front #(.FIELD_BITS(FIELD_BITS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .word_index_i, .lhs_word_i,
    .rhs_word_i, .start_product_i, .job_valid_o(job_valid),
    .job_ready_i(job_ready), .job_o(job)
  );

  gfm_engine #(.FIELD_BITS(FIELD_BITS)) u_engine (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .empty_o(empty), .pop_i(pop), .result_index_o,
    .result_word_o, .result_last_o
  );
endmodule
`default_nettype wire
